>>> rtl/caseless_pattern_search_core_macros.svh
// ----------------------------------------------------------------------------
// Caseless pattern search assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CASELESS_PATTERN_SEARCH_CORE_MACROS_SVH
`define CASELESS_PATTERN_SEARCH_CORE_MACROS_SVH

`ifndef SYNTH

// Property checked on every clock edge outside of reset
`define CPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cps: assertion failed");

// Property checked on every clock edge, reset included
`define CPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cps: assertion failed");

`else

`define CPS_ASSERT(lbl, clk, rst, prop)
`define CPS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// Caseless pattern search package
// Field widths, register indexes, the configuration bundle and case folding.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int CHAR_W    = 8;
  localparam int PAT_BYTES = 32;
  localparam int PAT_IDX_W = 5;
  localparam int LEN_W     = 6;
  localparam int OCC_W     = 16;
  localparam int OUT_CNT_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORD_BYTES = CFG_DATA_W / CHAR_W;

  localparam logic [CHAR_W-1:0] LINE_FEED   = 8'h0A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW      = 3'd0,
    CFG_PAT_MID_LOW  = 3'd1,
    CFG_PAT_MID_HIGH = 3'd2,
    CFG_PAT_HIGH     = 3'd3,
    CFG_PAT_LEN      = 3'd4,
    CFG_OCCURRENCE   = 3'd5,
    CFG_BACKWARD     = 3'd6
  } cfg_idx_t;

  // Configuration as seen by the datapath; pattern bytes are stored folded
  typedef struct packed {
    logic [PAT_BYTES-1:0][CHAR_W-1:0] pattern;
    logic [LEN_W-1:0]                 pat_len;
    logic [OCC_W-1:0]                 occurrence;
    logic                             backward;
  } cps_cfg_t;

  // Fold a..z to upper case
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

>>> rtl/cps_ifs.sv
// ----------------------------------------------------------------------------
// Caseless pattern search channels
// Valid/ready interfaces for the text stream, results and configuration.
// ----------------------------------------------------------------------------
interface cps_stream_if;
  import cps_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] stream_char;
  logic              last_char;
  modport source (output valid, stream_char, last_char, input ready);
  modport sink   (input valid, stream_char, last_char, output ready);
endinterface

interface cps_result_if;
  import cps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_CNT_W-1:0] position;
  logic [OUT_CNT_W-1:0] lines_crossed;
  modport source (output valid, found, position, lines_crossed, input ready);
  modport sink   (input valid, found, position, lines_crossed, output ready);
endinterface

interface cps_cfg_if;
  import cps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/cps_cfg_regs.sv
// ----------------------------------------------------------------------------
// Caseless pattern search configuration registers
// Register file behind the write channel; pattern bytes are folded on write.
// ----------------------------------------------------------------------------
module cps_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  cps_cfg_if.sink           cfg,
  output cps_pkg::cps_cfg_t regs
);
  import cps_pkg::*;

  logic wr_en;

  // Always ready; writes are registered
  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern    <= '0;
      regs.pat_len    <= LEN_W'(1);
      regs.occurrence <= OCC_W'(1);
      regs.backward   <= 1'b0;
    end else if (wr_en) begin
      case (cfg.index)
        CFG_PAT_LOW, CFG_PAT_MID_LOW, CFG_PAT_MID_HIGH, CFG_PAT_HIGH: begin
          for (int k = 0; k < WORD_BYTES; k++) begin
            regs.pattern[{cfg.index[1:0], 3'(k)}] <= fold(cfg.data[CHAR_W*k +: CHAR_W]);
          end
        end
        CFG_PAT_LEN:    regs.pat_len    <= cfg.data[LEN_W-1:0];
        CFG_OCCURRENCE: regs.occurrence <= cfg.data[OCC_W-1:0];
        CFG_BACKWARD:   regs.backward   <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/cps_window.sv
// ----------------------------------------------------------------------------
// Caseless pattern search window
// Shift line of recent folded bytes and the parallel compare against the
// pattern, taken over the window as it stands after the incoming byte.
// ----------------------------------------------------------------------------
module cps_window #(
  parameter int PATTERN_MAX = 32,
  parameter int LEN_BITS    = 6
) (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [cps_pkg::CHAR_W-1:0] char_in,
  input  cps_pkg::cps_cfg_t         regs,
  input  logic [LEN_BITS-1:0]       eff_len,
  output logic                      hit
);
  import cps_pkg::*;

  logic [CHAR_W-1:0] win      [PATTERN_MAX];
  logic [CHAR_W-1:0] win_new  [PATTERN_MAX];
  logic [CHAR_W-1:0] pat_sel  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] in_use;

  // Window after the incoming byte, newest at index 0
  always_comb begin
    win_new[0] = fold(char_in);
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_new[j] = win[j-1];
    end
  end

  // Pattern byte facing each window slot: direct in backward mode,
  // mirrored about the pattern length otherwise
  always_comb begin
    logic [LEN_BITS-1:0] ridx;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      ridx       = eff_len - LEN_BITS'(1) - LEN_BITS'(j);
      in_use[j]  = LEN_BITS'(j) < eff_len;
      pat_sel[j] = regs.backward ? regs.pattern[PAT_IDX_W'(j)]
                                 : regs.pattern[PAT_IDX_W'(ridx)];
      eq[j]      = win_new[j] == pat_sel[j];
    end
  end

  assign hit = &(eq | ~in_use);

  // Shift line
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win[j] <= win_new[j];
      end
    end
  end

endmodule

>>> rtl/caseless_pattern_search_core.sv
// ----------------------------------------------------------------------------
// Caseless pattern search core
// Searches a byte stream for a configured pattern, case-insensitive for a-z.
// ----------------------------------------------------------------------------
// Takes one text byte per clock and reports the requested non-overlapping
// occurrence of the pattern (found, byte count and newline count through the
// match end), or not found when the byte flagged last_char arrives first;
// after a result bytes are dropped up to last_char, which rearms the search.
// A byte goes through an input register, a window compare over all pattern
// bytes in parallel with the count update, and a result register. The block
// accepts one byte every cycle while the result register is empty or being
// taken. There is no clearing pass after reset. The user must write
// configuration only while no byte is in flight; the block itself does not
// enforce this.
`include "caseless_pattern_search_core_macros.svh"

module caseless_pattern_search_core #(
  parameter int PATTERN_MAX = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic         clk,
  input  logic         rst,
  cps_stream_if.sink   stream,
  cps_result_if.source result,
  cps_cfg_if.sink      cfg
);
  import cps_pkg::*;

  localparam int BSM_W = $clog2(PATTERN_MAX + 1);
  localparam logic [BSM_W-1:0]      BSM_MAX = BSM_W'(PATTERN_MAX);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [OCC_W-1:0]      OCC_MAX = '1;

  cps_cfg_t regs;

  // Input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;

  // Search state
  logic                  search_done;
  logic [BSM_W-1:0]      bsm;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] nl_cnt;
  logic [OCC_W-1:0]      matches_seen;

  // Result register
  logic                 out_valid;
  logic                 out_found;
  logic [OUT_CNT_W-1:0] out_pos;
  logic [OUT_CNT_W-1:0] out_lines;

  logic                  adv;
  logic                  proc;
  logic [BSM_W-1:0]      eff_len;
  logic [OCC_W-1:0]      want;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] nl_inc;
  logic [BSM_W-1:0]      bsm_inc;
  logic [OCC_W-1:0]      match_inc;
  logic                  win_hit;
  logic                  hit_ok;
  logic                  emit_found;
  logic                  emit;

  cps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cps_window #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_BITS    (BSM_W)
  ) u_window (
    .clk      (clk),
    .shift_en (proc && !search_done),
    .char_in  (s1_char),
    .regs     (regs),
    .eff_len  (eff_len),
    .hit      (win_hit)
  );

  // Handshake: the held byte moves on whenever the result slot is free
  assign adv          = !out_valid || result.ready;
  assign proc         = s1_valid && adv;
  assign stream.ready = !s1_valid || adv;

  // Effective pattern length and occurrence
  always_comb begin
    if (regs.pat_len == '0) begin
      eff_len = BSM_W'(1);
    end else if (int'(regs.pat_len) > PATTERN_MAX) begin
      eff_len = BSM_MAX;
    end else begin
      eff_len = BSM_W'(regs.pat_len);
    end
    want = (regs.occurrence == '0) ? OCC_W'(1) : regs.occurrence;
  end

  // Saturating counts and match decision for the held byte
  always_comb begin
    cnt_inc    = (cnt != CNT_MAX) ? cnt + COUNT_BITS'(1) : cnt;
    nl_inc     = (s1_char == LINE_FEED && nl_cnt != CNT_MAX) ? nl_cnt + COUNT_BITS'(1)
                                                             : nl_cnt;
    bsm_inc    = (bsm != BSM_MAX) ? bsm + BSM_W'(1) : bsm;
    match_inc  = (matches_seen != OCC_MAX) ? matches_seen + OCC_W'(1) : matches_seen;
    hit_ok     = (bsm_inc >= eff_len) && win_hit;
    emit_found = !search_done && hit_ok && (match_inc >= want);
    emit       = !search_done && (emit_found || s1_last);
  end

  // Control state; last_char always rearms
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      search_done  <= 1'b0;
      bsm          <= '0;
      cnt          <= '0;
      nl_cnt       <= '0;
      matches_seen <= '0;
    end else begin
      if (stream.valid && stream.ready) begin
        s1_valid <= 1'b1;
      end else if (proc) begin
        s1_valid <= 1'b0;
      end

      if (proc && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (proc) begin
        if (s1_last) begin
          search_done  <= 1'b0;
          bsm          <= '0;
          cnt          <= '0;
          nl_cnt       <= '0;
          matches_seen <= '0;
        end else if (!search_done) begin
          cnt    <= cnt_inc;
          nl_cnt <= nl_inc;
          bsm    <= hit_ok ? '0 : bsm_inc;
          if (hit_ok) begin
            matches_seen <= match_inc;
          end
          if (emit_found) begin
            search_done <= 1'b1;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_char <= stream.stream_char;
      s1_last <= stream.last_char;
    end
    if (proc && emit) begin
      out_found <= emit_found;
      out_pos   <= emit_found ? OUT_CNT_W'(cnt_inc) : '0;
      out_lines <= emit_found ? OUT_CNT_W'(nl_inc) : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.found         = out_found;
  assign result.position      = out_pos;
  assign result.lines_crossed = out_lines;

  // Checks
  `CPS_ASSERT(a_bsm_bound, clk, rst, bsm <= BSM_MAX)
  `CPS_ASSERT(a_nl_le_cnt, clk, rst, nl_cnt <= cnt)
  `CPS_ASSERT(a_not_found_zero, clk, rst, out_valid && !out_found |-> out_pos == '0 && out_lines == '0)
  `CPS_ASSERT(a_last_rearms, clk, rst, proc && s1_last |=> cnt == '0 && matches_seen == '0 && !search_done)
  `CPS_ASSERT(a_done_silent, clk, rst, proc && search_done && !s1_last |=> $stable(cnt) && $stable(nl_cnt))

endmodule
